// File: rtl/tsp_pkg.sv
package tsp_pkg;

    // Packet geometry
    localparam int PktWords = 47;
    localparam logic [5:0] LastWordIdx = 6'd46;
    localparam logic [5:0] FirstPayloadIdx = 6'd4;
    localparam logic [7:0] MaxPayload = 8'd170;
    localparam int MaxStreams = 3;

    // Input commands
    localparam logic [1:0] FuncPat = 2'd0;
    localparam logic [1:0] FuncPmt = 2'd1;
    localparam logic [1:0] FuncOpen = 2'd2;
    localparam logic [1:0] FuncByte = 2'd3;

    // Burst kinds handed to the word emitter
    localparam logic [1:0] KindPat = 2'd0;
    localparam logic [1:0] KindPmt = 2'd1;
    localparam logic [1:0] KindEs = 2'd2;

    // One burst of output words: indexes start to last of a packet
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  stream;
        logic [3:0]  count;
        logic [32:0] pts;
        logic [7:0]  length;
        logic [5:0]  first_idx;
        logic [31:0] first_word;
        logic [5:0]  start;
        logic [5:0]  last;
    } tsp_job_t;

    // Program association table, byte by byte, padded with 0xFF.
    function automatic logic [7:0] pat_byte(input logic [7:0] idx, input logic [3:0] cnt);
        logic [7:0] b;
        case (idx)
            8'd0:  b = 8'h47;
            8'd1:  b = 8'h40;
            8'd3:  b = {4'h1, cnt};
            8'd2, 8'd4, 8'd5, 8'd8, 8'd11, 8'd12, 8'd13, 8'd17, 8'd21: b = 8'h00;
            8'd6:  b = 8'h80;
            8'd7:  b = 8'h15;
            8'd9:  b = 8'h01;
            8'd10: b = 8'hDB;
            8'd14: b = 8'h01;
            8'd15: b = 8'hE1;
            8'd16: b = 8'h02;
            8'd18: b = 8'h02;
            8'd19: b = 8'hE1;
            8'd20: b = 8'h03;
            8'd22: b = 8'h03;
            8'd23: b = 8'hE1;
            8'd24: b = 8'h04;
            8'd25: b = 8'h4C;
            8'd26: b = 8'h76;
            8'd27: b = 8'h85;
            8'd28: b = 8'h3A;
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

    // Stored CRC of each stream's map table.
    function automatic logic [31:0] pmt_crc(input logic [1:0] s);
        logic [31:0] c;
        case (s)
            2'd0:    c = 32'h36B8219F;
            2'd1:    c = 32'hDBC3DFA7;
            default: c = 32'hED4B3D34;
        endcase
        return c;
    endfunction

    // Program map table of one stream, byte by byte, padded with 0xFF.
    function automatic logic [7:0] pmt_byte(input logic [7:0] idx, input logic [1:0] s,
                                            input logic [3:0] cnt);
        logic [7:0]  b;
        logic [31:0] crc;
        crc = pmt_crc(s);
        case (idx)
            8'd0:  b = 8'h47;
            8'd1:  b = 8'h41;
            8'd2:  b = 8'h02 + {6'b0, s};
            8'd3:  b = {4'h1, cnt};
            8'd4, 8'd8, 8'd11, 8'd12, 8'd20: b = 8'h00;
            8'd5:  b = 8'h02;
            8'd6:  b = 8'hB0;
            8'd7:  b = 8'h21;
            8'd9:  b = 8'h01;
            8'd10: b = 8'hC3;
            8'd13, 8'd23: b = 8'hE2;
            8'd14, 8'd24: b = 8'h94 + {6'b0, s};
            8'd15, 8'd25: b = 8'hF0;
            8'd16: b = 8'h05;
            8'd17: b = 8'h0E;
            8'd18: b = 8'h03;
            8'd19: b = 8'hC0;
            8'd21: b = 8'h96;
            8'd22: b = 8'h06;
            8'd26: b = 8'h0A;
            8'd27: b = 8'h05;
            8'd28: b = 8'h04;
            8'd29: b = 8'h44;
            8'd30: b = 8'h52;
            8'd31: b = 8'h41;
            8'd32: b = 8'h31;
            8'd33: b = 8'hA0;
            8'd34: b = 8'h02;
            8'd35: b = 8'h50;
            8'd36: b = 8'h40;
            8'd37: b = crc[31:24];
            8'd38: b = crc[23:16];
            8'd39: b = crc[15:8];
            8'd40: b = crc[7:0];
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/tsp_emitter.sv
module tsp_emitter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_load,
    input  tsp_pkg::tsp_job_t job,
    output logic              can_take,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // packet_word
    output logic              m_tlast    // last_word
);
    import tsp_pkg::*;

    logic        busy_reg, busy_next;
    tsp_job_t    job_reg, job_next;
    logic [5:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [31:0] data_reg, data_next;
    logic        last_reg, last_next;

    logic        out_free;
    logic        step;
    logic        final_step;
    logic [31:0] word;
    logic [7:0]  byte_base;
    logic [31:0] es_word;

    assign out_free   = !valid_reg || m_tready;
    assign step       = busy_reg && out_free;
    assign final_step = (idx_reg == job_reg.last);
    assign can_take   = !busy_reg || (final_step && out_free);
    assign byte_base  = {idx_reg, 2'b00};

    // Elementary stream words: header, then the job's first word at its index, then 0xFF fill.
    always_comb begin
        case (idx_reg)
            6'd0: es_word = {8'h47, 8'h42, 8'h94 + {6'b0, job_reg.stream},
                             4'h1, job_reg.count};
            6'd1: es_word = 32'h000001BD;
            6'd2: es_word = {8'h00, job_reg.length + 8'd8, 8'h80, 8'h80};
            6'd3: es_word = {8'h05, 4'b0010, job_reg.pts[32:30], 1'b1,
                             job_reg.pts[29:22], job_reg.pts[21:15], 1'b1};
            default: begin
                if (idx_reg == job_reg.first_idx) begin
                    es_word = job_reg.first_word;
                end else begin
                    es_word = 32'hFFFFFFFF;
                end
            end
        endcase
    end

    // Word selection for the current burst index
    always_comb begin
        unique case (job_reg.kind)
            KindPat: word = {pat_byte(byte_base, job_reg.count),
                             pat_byte(byte_base + 8'd1, job_reg.count),
                             pat_byte(byte_base + 8'd2, job_reg.count),
                             pat_byte(byte_base + 8'd3, job_reg.count)};
            KindPmt: word = {pmt_byte(byte_base, job_reg.stream, job_reg.count),
                             pmt_byte(byte_base + 8'd1, job_reg.stream, job_reg.count),
                             pmt_byte(byte_base + 8'd2, job_reg.stream, job_reg.count),
                             pmt_byte(byte_base + 8'd3, job_reg.stream, job_reg.count)};
            default: word = es_word;
        endcase
    end

    // Burst sequencing and the output register
    always_comb begin
        busy_next  = busy_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (step) begin
            valid_next = 1'b1;
            data_next  = word;
            last_next  = (idx_reg == LastWordIdx);
            idx_next   = idx_reg + 6'd1;
            if (final_step) begin
                busy_next = 1'b0;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
        if (job_load) begin
            busy_next = 1'b1;
            job_next  = job;
            idx_next  = job.start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
        job_reg  <= job_next;
        idx_reg  <= idx_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// File: rtl/transport_stream_packetizer.sv
// Transport stream packetizer. Every packet is 188 bytes and leaves as 47 big-endian
// 32-bit words on the m_ channel, with m_tlast on the last word. A PAT or PMT command
// produces a whole table packet, and an open command produces the four TS and PES header
// words (and, for a zero length, the whole padded packet). Payload bytes are then taken
// one per cycle while the receiver keeps up, and leave four to a word; the byte that
// completes the declared length also releases the padding words. One output word
// register sets the rate: s_tready stays low while a burst drains (47 words for a table
// packet or an empty open, 4 for any other open, up to 43 for the word and the padding
// that close a packet), while payload bytes flow at one transfer per cycle if the
// receiver keeps up. Commands other than payload bytes are ignored while a packet is
// open, and cfg_data (the PTS increment) may be written at any time the block is idle.
module transport_stream_packetizer #(
    parameter int NUM_STREAMS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // stream[1:0], payload_length[9:2], data_byte[17:10]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // packet_word[31:0]
    output logic        m_tlast,   // last_word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [32:0] cfg_data   // pts_increment
);
    import tsp_pkg::*;

    logic [32:0] pts_inc_reg;
    logic [3:0]  pat_count_reg, pat_count_next;
    logic [3:0]  pmt_count_reg [MaxStreams];
    logic [3:0]  pmt_count_next [MaxStreams];
    logic [3:0]  es_count_reg [MaxStreams];
    logic [3:0]  es_count_next [MaxStreams];
    logic [32:0] es_time_reg [MaxStreams];
    logic [32:0] es_time_next [MaxStreams];
    logic        open_reg, open_next;
    logic [1:0]  open_stream_reg, open_stream_next;
    logic [7:0]  decl_reg, decl_next;
    logic [7:0]  taken_reg, taken_next;
    logic [23:0] pend_reg, pend_next;
    logic [1:0]  pcnt_reg, pcnt_next;
    logic [5:0]  wsent_reg, wsent_next;

    logic        in_xfer;
    logic [1:0]  func;
    logic [1:0]  stream_sel;
    logic [7:0]  len_in;
    logic [7:0]  len_sat;
    logic [7:0]  data_in;
    logic        stream_ok;
    logic [7:0]  taken_inc;
    logic        job_load;
    tsp_job_t    job;
    logic [32:0] open_time;
    logic [31:0] fin_word;

    logic        can_take;

    assign func       = s_tuser;
    assign stream_sel = s_tdata[1:0];
    assign len_in     = s_tdata[9:2];
    assign data_in    = s_tdata[17:10];
    assign len_sat    = (len_in > MaxPayload) ? MaxPayload : len_in;
    assign stream_ok  = (int'(stream_sel) < NUM_STREAMS) && (int'(stream_sel) < MaxStreams);
    assign in_xfer    = s_tvalid && s_tready;
    assign s_tready   = can_take;
    assign cfg_ready  = 1'b1;
    assign taken_inc  = taken_reg + 8'd1;
    assign open_time  = es_time_reg[stream_sel];

    // Last data word of a packet: pending bytes, the new byte, then 0xFF fill.
    always_comb begin
        case (pcnt_reg)
            2'd0:    fin_word = {data_in, 24'hFFFFFF};
            2'd1:    fin_word = {pend_reg[7:0], data_in, 16'hFFFF};
            2'd2:    fin_word = {pend_reg[15:0], data_in, 8'hFF};
            default: fin_word = {pend_reg, data_in};
        endcase
    end

    // Per-transfer state update and burst set-up
    always_comb begin
        pat_count_next   = pat_count_reg;
        pmt_count_next   = pmt_count_reg;
        es_count_next    = es_count_reg;
        es_time_next     = es_time_reg;
        open_next        = open_reg;
        open_stream_next = open_stream_reg;
        decl_next        = decl_reg;
        taken_next       = taken_reg;
        pend_next        = pend_reg;
        pcnt_next        = pcnt_reg;
        wsent_next       = wsent_reg;
        job_load         = 1'b0;
        job              = '0;
        job.kind         = KindEs;

        if (in_xfer) begin
            if (func == FuncByte) begin
                if (open_reg) begin
                    taken_next     = taken_inc;
                    job.stream     = open_stream_reg;
                    if (taken_inc >= decl_reg) begin
                        // Packet complete: flush and pad to the end
                        job_load       = 1'b1;
                        job.first_idx  = wsent_reg;
                        job.first_word = fin_word;
                        job.start      = wsent_reg;
                        job.last       = LastWordIdx;
                        open_next      = 1'b0;
                        wsent_next     = 6'd0;
                        pend_next      = 24'd0;
                        pcnt_next      = 2'd0;
                        es_count_next[open_stream_reg] = es_count_reg[open_stream_reg] + 4'd1;
                        es_time_next[open_stream_reg] = es_time_reg[open_stream_reg]
                                                        + pts_inc_reg;
                    end else if (pcnt_reg == 2'd3) begin
                        // Fourth byte completes a data word
                        job_load       = 1'b1;
                        job.first_idx  = wsent_reg;
                        job.first_word = {pend_reg, data_in};
                        job.start      = wsent_reg;
                        job.last       = wsent_reg;
                        wsent_next     = wsent_reg + 6'd1;
                        pend_next      = 24'd0;
                        pcnt_next      = 2'd0;
                    end else begin
                        pend_next = {pend_reg[15:0], data_in};
                        pcnt_next = pcnt_reg + 2'd1;
                    end
                end
            end else if (!open_reg) begin
                case (func)
                    FuncPat: begin
                        job_load       = 1'b1;
                        job.kind       = KindPat;
                        job.count      = pat_count_reg;
                        job.start      = 6'd0;
                        job.last       = LastWordIdx;
                        pat_count_next = pat_count_reg + 4'd1;
                    end
                    FuncPmt: begin
                        if (stream_ok) begin
                            job_load   = 1'b1;
                            job.kind   = KindPmt;
                            job.stream = stream_sel;
                            job.count  = pmt_count_reg[stream_sel];
                            job.start  = 6'd0;
                            job.last   = LastWordIdx;
                            pmt_count_next[stream_sel] = pmt_count_reg[stream_sel] + 4'd1;
                        end
                    end
                    default: begin
                        if (stream_ok) begin
                            job_load       = 1'b1;
                            job.stream     = stream_sel;
                            job.count      = es_count_reg[stream_sel];
                            job.pts        = open_time;
                            job.length     = len_sat;
                            job.start      = 6'd0;
                            job.first_idx  = FirstPayloadIdx;
                            job.first_word = {open_time[14:7], open_time[6:0], 1'b1,
                                              16'hFFFF};
                            if (len_sat == 8'd0) begin
                                // Empty payload: header, then padding at once
                                job.last = LastWordIdx;
                                es_count_next[stream_sel] = es_count_reg[stream_sel] + 4'd1;
                                es_time_next[stream_sel] = open_time + pts_inc_reg;
                            end else begin
                                job.last         = FirstPayloadIdx - 6'd1;
                                open_next        = 1'b1;
                                open_stream_next = stream_sel;
                                decl_next        = len_sat;
                                taken_next       = 8'd0;
                                wsent_next       = FirstPayloadIdx;
                                pend_next        = {8'h00, open_time[14:7],
                                                    open_time[6:0], 1'b1};
                                pcnt_next        = 2'd2;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pts_inc_reg     <= 33'd3840;
            pat_count_reg   <= 4'd0;
            open_reg        <= 1'b0;
            open_stream_reg <= 2'd0;
            decl_reg        <= 8'd0;
            taken_reg       <= 8'd0;
            pend_reg        <= 24'd0;
            pcnt_reg        <= 2'd0;
            wsent_reg       <= 6'd0;
            for (int i = 0; i < MaxStreams; i++) begin
                pmt_count_reg[i] <= 4'd0;
                es_count_reg[i]  <= 4'd0;
                es_time_reg[i]   <= 33'd0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                pts_inc_reg <= cfg_data;
            end
            pat_count_reg   <= pat_count_next;
            open_reg        <= open_next;
            open_stream_reg <= open_stream_next;
            decl_reg        <= decl_next;
            taken_reg       <= taken_next;
            pend_reg        <= pend_next;
            pcnt_reg        <= pcnt_next;
            wsent_reg       <= wsent_next;
            pmt_count_reg   <= pmt_count_next;
            es_count_reg    <= es_count_next;
            es_time_reg     <= es_time_next;
        end
    end

    tsp_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_load (job_load),
        .job      (job),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
